>>> hw/rtl/cbdma_pkg.sv
package cbdma_pkg;

  // Default work RAM size in bytes.
  localparam int unsigned RAM_DEPTH_DEF = 2048;

  // CPU bus address map.
  localparam logic [15:0] ADDR_RAM_TOP   = 16'h1FFF;
  localparam logic [15:0] ADDR_PPU_TOP   = 16'h3FFF;
  localparam logic [15:0] ADDR_OAM_DMA   = 16'h4014;
  localparam logic [15:0] ADDR_PAD0      = 16'h4016;
  localparam logic [15:0] ADDR_PAD1      = 16'h4017;
  localparam logic [15:0] ADDR_CART_BASE = 16'h4020;

  // Last sprite memory index of a DMA run.
  localparam logic [7:0] OAM_LAST = 8'hFF;

  typedef enum logic [1:0] {
    CMD_RD  = 2'd0,
    CMD_WR  = 2'd1,
    CMD_DMA = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    RT_RAM  = 3'd0,
    RT_PAD  = 3'd1,
    RT_PPU  = 3'd2,
    RT_CART = 3'd3,
    RT_DMA  = 3'd4,
    RT_NONE = 3'd5
  } route_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    route_t      route;
    logic [7:0]  rdata;
    logic [15:0] ext_addr;
    logic [7:0]  ext_wdata;
    logic        oam_we;
    logic [7:0]  oam_addr;
    logic [7:0]  oam_data;
    logic        dma_busy;
  } res_t;

endpackage

>>> hw/rtl/cbdma_req_if.sv
interface cbdma_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [7:0]  pad0;
  logic [7:0]  pad1;
  logic [7:0]  ext_rdata;

  modport source (
    output valid, cmd, addr, wdata, pad0, pad1, ext_rdata,
    input  ready
  );

  modport sink (
    input  valid, cmd, addr, wdata, pad0, pad1, ext_rdata,
    output ready
  );
endinterface

>>> hw/rtl/cbdma_rsp_if.sv
interface cbdma_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  route;
  logic [7:0]  rdata;
  logic [15:0] ext_addr;
  logic [7:0]  ext_wdata;
  logic        oam_we;
  logic [7:0]  oam_addr;
  logic [7:0]  oam_data;
  logic        dma_busy;

  modport source (
    output valid, route, rdata, ext_addr, ext_wdata, oam_we, oam_addr, oam_data, dma_busy,
    input  ready
  );

  modport sink (
    input  valid, route, rdata, ext_addr, ext_wdata, oam_we, oam_addr, oam_data, dma_busy,
    output ready
  );
endinterface

>>> hw/rtl/cbdma_ram.sv
module cbdma_ram
  import cbdma_pkg::*;
#(
  parameter  int unsigned DEPTH = RAM_DEPTH_DEF,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data registered, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/cpu_bus_decoder_with_oam_dma.sv
// CPU bus decoder with sprite DMA.
//
// Input channel req carries one beat per bus item: a CPU read, a CPU write or
// a DMA tick, with the address, write byte, both pad inputs and the byte the
// PPU/cartridge answers for a DMA source read. Output channel rsp returns one
// beat per item: route, read byte, forwarded address/byte, the sprite memory
// write of this tick and the DMA busy flag after the item.
//
// Each item is handled in order: the beat is taken and the work RAM read is
// issued, then the RAM data returns and the item commits (RAM write, pad
// latches, DMA registers) into the output register. The registered read of
// the single-read-port RAM parts these steps, and a new beat is not taken
// until the last item has committed. The output register parts the channels:
// a new beat is taken while a finished result still waits; if rsp stalls, the
// next item holds in its commit cycle until the output register frees up.
//
// After reset the work RAM is swept to zero, one byte a cycle over all
// RAM_DEPTH bytes, with req.ready low. Pad latches and DMA state reset to zero.
module cpu_bus_decoder_with_oam_dma
  import cbdma_pkg::*;
#(
  parameter int unsigned RAM_DEPTH = RAM_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  cbdma_req_if.sink   req,
  cbdma_rsp_if.source rsp
);

  localparam int unsigned AW = $clog2(RAM_DEPTH);

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  state_t state, state_next;

  logic          accept;
  logic          commit;
  logic          out_free;
  logic          clear_we;
  logic [AW-1:0] clr_idx;
  logic          clr_last;
  logic          out_valid;

  // Architectural state (RAM lives in cbdma_ram)
  logic [1:0][7:0] pad_shift, pad_next;
  logic [7:0]      dma_page, page_next;
  logic [7:0]      dma_offset, offset_next;
  logic [7:0]      dma_latch, latch_next;
  logic            dma_active, active_next;
  logic            dma_phase, phase_next;

  // Captured item
  logic [1:0]    it_cmd;
  logic [15:0]   it_addr;
  logic [7:0]    it_wdata;
  logic [7:0]    it_pad0;
  logic [7:0]    it_pad1;
  logic [7:0]    it_ext;
  logic [AW-1:0] it_ridx;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_q;
  logic          ram_wr;

  res_t res, res_q;

  // ---------------------------------------------------------------------------
  // Mirroring: index = addr mod RAM_DEPTH for addr <= 0x1FFF.
  // addr = hi*256 + lo; table holds (hi*256) mod RAM_DEPTH, then one
  // compare/subtract since table + lo < 2*RAM_DEPTH.
  // ---------------------------------------------------------------------------
  logic [AW-1:0] mir_tab [32];

  for (genvar h = 0; h < 32; h++) begin : g_mir
    localparam int unsigned MV = (h * 256) % RAM_DEPTH;
    assign mir_tab[h] = AW'(MV);
  end

  logic [15:0]   src_addr;
  logic [AW:0]   mir_sum;
  logic [AW-1:0] src_ridx;

  // DMA ticks read the source byte at page:offset; CPU items use their address
  assign src_addr = (req.cmd == CMD_DMA) ? {dma_page, dma_offset} : req.addr;
  assign mir_sum  = {1'b0, mir_tab[src_addr[12:8]]} + (AW+1)'(src_addr[7:0]);
  assign src_ridx = (mir_sum >= (AW+1)'(RAM_DEPTH)) ?
                    AW'(mir_sum - (AW+1)'(RAM_DEPTH)) : mir_sum[AW-1:0];

  // ---------------------------------------------------------------------------
  // State machine
  // ---------------------------------------------------------------------------
  assign clr_last = (clr_idx == AW'(RAM_DEPTH - 1));
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (req.valid) state_next = ST_EXEC;
      ST_EXEC:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    commit    = 1'b0;
    clear_we  = 1'b0;
    unique case (state)
      ST_CLEAR: clear_we  = 1'b1;
      ST_IDLE:  req.ready = 1'b1;
      ST_EXEC:  commit    = out_free;
      default:  ;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (clear_we) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item capture
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      it_cmd   <= req.cmd;
      it_addr  <= req.addr;
      it_wdata <= req.wdata;
      it_pad0  <= req.pad0;
      it_pad1  <= req.pad1;
      it_ext   <= req.ext_rdata;
      it_ridx  <= src_ridx;
    end
  end

  // ---------------------------------------------------------------------------
  // Work RAM: read at accept, write at commit or during the clear sweep
  // ---------------------------------------------------------------------------
  assign ram_we    = clear_we || (commit && ram_wr);
  assign ram_waddr = clear_we ? clr_idx : it_ridx;
  assign ram_wdata = clear_we ? 8'd0 : it_wdata;

  cbdma_ram #(
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (src_ridx),
    .rdata (ram_q)
  );

  // ---------------------------------------------------------------------------
  // Read decode (CPU read or DMA source read)
  // ---------------------------------------------------------------------------
  logic [15:0] ea;
  route_t      rd_route;
  logic [7:0]  rd_val;
  logic [15:0] rd_fwd;
  logic        pad_pop;

  // page/offset are unchanged between accept and commit
  assign ea = (it_cmd == CMD_DMA) ? {dma_page, dma_offset} : it_addr;

  always_comb begin
    rd_route = RT_NONE;
    rd_val   = 8'd0;
    rd_fwd   = 16'd0;
    pad_pop  = 1'b0;
    if (ea <= ADDR_RAM_TOP) begin
      rd_route = RT_RAM;
      rd_val   = ram_q;
    end else if (ea <= ADDR_PPU_TOP) begin
      rd_route = RT_PPU;
      rd_fwd   = ea;
    end else if (ea == ADDR_PAD0 || ea == ADDR_PAD1) begin
      rd_route = RT_PAD;
      rd_val   = {7'd0, pad_shift[ea[0]][7]};
      pad_pop  = 1'b1;
    end else if (ea >= ADDR_CART_BASE) begin
      rd_route = RT_CART;
      rd_fwd   = ea;
    end
  end

  // ---------------------------------------------------------------------------
  // Item execution: result and next state
  // ---------------------------------------------------------------------------
  always_comb begin
    res         = '0;
    res.route   = RT_NONE;
    pad_next    = pad_shift;
    page_next   = dma_page;
    offset_next = dma_offset;
    latch_next  = dma_latch;
    active_next = dma_active;
    phase_next  = dma_phase;
    ram_wr      = 1'b0;

    case (it_cmd)
      CMD_RD: begin
        res.route    = rd_route;
        res.rdata    = rd_val;
        res.ext_addr = rd_fwd;
        if (pad_pop) begin
          pad_next[ea[0]] = {pad_shift[ea[0]][6:0], 1'b0};
        end
      end
      CMD_WR: begin
        if (it_addr <= ADDR_RAM_TOP) begin
          ram_wr    = 1'b1;
          res.route = RT_RAM;
        end else if (it_addr == ADDR_PAD0 || it_addr == ADDR_PAD1) begin
          // latch the live buttons; write data is ignored
          pad_next[it_addr[0]] = it_addr[0] ? it_pad1 : it_pad0;
          res.route            = RT_PAD;
        end else if (it_addr <= ADDR_PPU_TOP) begin
          res.route     = RT_PPU;
          res.ext_addr  = it_addr;
          res.ext_wdata = it_wdata;
        end else if (it_addr == ADDR_OAM_DMA) begin
          // (re)start sprite DMA from page wdata
          page_next   = it_wdata;
          offset_next = 8'd0;
          active_next = 1'b1;
          phase_next  = 1'b0;
          res.route   = RT_DMA;
        end
      end
      CMD_DMA: begin
        if (dma_active) begin
          if (!dma_phase) begin
            // source read tick
            res.route    = rd_route;
            res.rdata    = rd_val;
            res.ext_addr = rd_fwd;
            if (pad_pop) begin
              pad_next[ea[0]] = {pad_shift[ea[0]][6:0], 1'b0};
            end
            if (rd_route == RT_RAM || rd_route == RT_PAD) begin
              latch_next = rd_val;
            end else if (rd_route == RT_PPU || rd_route == RT_CART) begin
              latch_next = it_ext;
            end
            phase_next = 1'b1;
          end else begin
            // sprite memory write tick
            res.oam_we   = 1'b1;
            res.oam_addr = dma_offset;
            res.oam_data = dma_latch;
            offset_next  = dma_offset + 8'd1;
            if (dma_offset == OAM_LAST) begin
              active_next = 1'b0;
            end
            phase_next = 1'b0;
          end
        end
      end
      default: ;
    endcase

    res.dma_busy = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_shift  <= '0;
      dma_page   <= 8'd0;
      dma_offset <= 8'd0;
      dma_latch  <= 8'd0;
      dma_active <= 1'b0;
      dma_phase  <= 1'b0;
    end else if (commit) begin
      pad_shift  <= pad_next;
      dma_page   <= page_next;
      dma_offset <= offset_next;
      dma_latch  <= latch_next;
      dma_active <= active_next;
      dma_phase  <= phase_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_q <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.route     = res_q.route;
  assign rsp.rdata     = res_q.rdata;
  assign rsp.ext_addr  = res_q.ext_addr;
  assign rsp.ext_wdata = res_q.ext_wdata;
  assign rsp.oam_we    = res_q.oam_we;
  assign rsp.oam_addr  = res_q.oam_addr;
  assign rsp.oam_data  = res_q.oam_data;
  assign rsp.dma_busy  = res_q.dma_busy;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_oam_we_no_bus: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.oam_we |-> rsp.route == RT_NONE && rsp.dma_busy == (rsp.oam_addr != OAM_LAST))
    else $error("sprite write tick with bus route or wrong busy flag");

  a_phase_needs_active: assert property (@(posedge clk) disable iff (rst)
    dma_phase |-> dma_active)
    else $error("dma phase set while dma idle");

  a_commit_fills_out: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp.valid)
    else $error("committed item missing from output register");

  a_dma_ends: assert property (@(posedge clk) disable iff (rst)
    commit && it_cmd == CMD_DMA && dma_active && dma_phase && dma_offset == OAM_LAST
    |=> !dma_active)
    else $error("dma did not stop after last sprite byte");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |=> !commit || $past(clr_last))
    else $error("item committed during ram clear");

endmodule
